/* rtl/jfme_pkg.sv */
// Shared constants and types of the JPEG frame marker extractor.
package jfme_pkg;

   localparam int unsigned BUFFER_BYTES = 524288;

   localparam int unsigned POS_W    = 20;
   localparam int unsigned OFFSET_W = 19;
   localparam int unsigned LENGTH_W = 20;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_START = 2'd1;
   localparam logic [1:0] ST_NO_END   = 2'd2;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // One queue entry: up to two data results followed by an optional status result.
   typedef struct packed {
      logic [7:0]          data_byte;
      logic [1:0]          data_count;
      logic                frame_last;
      logic [LENGTH_W-1:0] frame_length;
      logic [OFFSET_W-1:0] start_offset;
      logic [1:0]          err_status;
   } cmd_type;

endpackage

/* rtl/jfme_front.sv */
// Front end: accepts bytes, tracks the marker search and queues result commands.
module jfme_front import jfme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    cmd
);

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_FRAME  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [7:0]          prev_byte_ff, prev_byte_in;
   logic                prev_valid_ff, prev_valid_in;
   logic [1:0]          phase_ff, phase_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [OFFSET_W-1:0] frame_start_ff, frame_start_in;
   logic [LENGTH_W-1:0] byte_count_ff, byte_count_in;

   logic                accept;
   logic                end_of_buf;
   logic                prev_ff;
   logic [POS_W-1:0]    pos_dec;
   logic [LENGTH_W-1:0] count_inc;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign end_of_buf = req_tlast || (position_ff >= LAST_POS);
   assign prev_ff    = prev_valid_ff && (prev_byte_ff == MARKER_PREFIX);
   assign pos_dec    = position_ff - POS_W'(1);
   assign count_inc  = byte_count_ff + LENGTH_W'(1);

   always_comb begin
      prev_byte_in   = prev_byte_ff;
      prev_valid_in  = prev_valid_ff;
      phase_in       = phase_ff;
      frame_start_in = frame_start_ff;
      byte_count_in  = byte_count_ff;
      position_in    = position_ff + POS_W'(1);
      cmd            = '0;

      unique case (phase_ff)
         PH_SEARCH: begin
            if (prev_ff && req_tdata == MARKER_SOI) begin
               frame_start_in   = pos_dec[OFFSET_W-1:0];
               byte_count_in    = LENGTH_W'(2);
               phase_in         = PH_FRAME;
               cmd.data_count   = 2'd2;
               cmd.data_byte    = MARKER_SOI;
               cmd.start_offset = pos_dec[OFFSET_W-1:0];
            end
            prev_byte_in  = req_tdata;
            prev_valid_in = 1'b1;
         end
         PH_FRAME: begin
            byte_count_in    = count_inc;
            cmd.data_count   = 2'd1;
            cmd.data_byte    = req_tdata;
            cmd.start_offset = frame_start_ff;
            if (prev_ff && req_tdata == MARKER_EOI) begin
               cmd.frame_last   = 1'b1;
               cmd.frame_length = count_inc;
               phase_in         = PH_DONE;
            end
            prev_byte_in  = req_tdata;
            prev_valid_in = 1'b1;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (end_of_buf) begin
         if (phase_in == PH_SEARCH) begin
            cmd.err_status   = ST_NO_START;
            cmd.start_offset = '0;
         end else if (phase_in == PH_FRAME) begin
            cmd.err_status   = ST_NO_END;
            cmd.start_offset = frame_start_in;
         end
         // Every buffer starts from a clean state.
         prev_byte_in   = '0;
         prev_valid_in  = 1'b0;
         phase_in       = PH_SEARCH;
         position_in    = '0;
         frame_start_in = '0;
         byte_count_in  = '0;
      end
   end

   assign push = accept && (cmd.data_count != 2'd0 || cmd.err_status != ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff   <= '0;
         prev_valid_ff  <= 1'b0;
         phase_ff       <= PH_SEARCH;
         position_ff    <= '0;
         frame_start_ff <= '0;
         byte_count_ff  <= '0;
      end else if (accept) begin
         prev_byte_ff   <= prev_byte_in;
         prev_valid_ff  <= prev_valid_in;
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         frame_start_ff <= frame_start_in;
         byte_count_ff  <= byte_count_in;
      end
   end

endmodule

/* rtl/jfme_queue.sv */
// Short command queue between the front and back ends.
module jfme_queue import jfme_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   cmd_type entries_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/jfme_back.sv */
// Back end: expands each queued command into result transfers via an output register.
module jfme_back import jfme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head_cmd,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser
);

   logic [1:0]          step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                is_data_ff, is_data_in;
   logic                frame_last_ff, frame_last_in;
   logic [LENGTH_W-1:0] frame_length_ff, frame_length_in;
   logic [OFFSET_W-1:0] start_offset_ff, start_offset_in;
   logic [1:0]          status_ff, status_in;

   logic       load;
   logic [1:0] total;
   logic       last_step;

   assign total     = head_cmd.data_count + {1'b0, head_cmd.err_status != ST_OK};
   assign last_step = (step_ff == total - 2'd1);
   assign load      = !empty && (!out_valid_ff || rsp_tready);
   assign pop       = load && last_step;

   always_comb begin
      step_in         = step_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      is_data_in      = step_ff < head_cmd.data_count;
      out_byte_in     = '0;
      frame_last_in   = 1'b0;
      frame_length_in = '0;
      start_offset_in = head_cmd.start_offset;
      status_in       = head_cmd.err_status;
      if (is_data_in) begin
         status_in = ST_OK;
         // A start marker comes out as its prefix byte and then the SOI byte.
         if (head_cmd.data_count == 2'd2 && step_ff == 2'd0) begin
            out_byte_in = MARKER_PREFIX;
         end else begin
            out_byte_in = head_cmd.data_byte;
         end
         frame_last_in   = head_cmd.frame_last;
         frame_length_in = head_cmd.frame_length;
      end
      if (load) begin
         out_valid_in = 1'b1;
         step_in      = last_step ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff     <= out_byte_in;
         is_data_ff      <= is_data_in;
         frame_last_ff   <= frame_last_in;
         frame_length_ff <= frame_length_in;
         start_offset_ff <= start_offset_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, start_offset_ff, frame_length_ff, out_byte_ff};
   assign rsp_tlast  = frame_last_ff;
   assign rsp_tuser  = {status_ff, is_data_ff};

endmodule

/* rtl/jpeg_frame_marker_extractor_unit.sv */
// Top level of the JPEG frame marker extractor.
//
// The req channel takes one captured byte per transfer, with req_tlast on the
// final byte of the capture buffer. The rsp channel gives the frame bytes from
// the FF D8 start marker through the FF D9 end marker; the D9 byte carries
// rsp_tlast, the frame length and the start offset. A buffer that ends without
// a complete frame gives one status-only transfer with an error code.
// The front end classifies a byte as it is taken and writes a command into a
// four-entry queue at the same edge. The back end expands a command into up to
// three results through an output register. The first result of a byte passes
// through its queue entry and then the output register, and waits in the queue
// while that register is held. One byte is taken per cycle; the rate falls only
// while the queue is full, which happens behind a stalled receiver or when start
// markers and status results add results faster than the spare slots take them.
// When rsp_tready is low the output register holds its result, the queue fills
// and req_tready drops once it holds four commands.
// Reset clears the marker search, the buffer position, the queue and the
// output register; no clearing pass is needed.
module jpeg_frame_marker_extractor_unit import jfme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [27:8] frame_length,
                                    // [46:28] start_offset, [47] zero
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser    // [0] is_data, [2:1] status
);

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    empty;
   logic    full;

   jfme_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   jfme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   jfme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue written while full");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser[0] && rsp_tuser[2:1] == ST_OK))
      else $error("frame end without ok data result");

   a_status_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[2:1] != ST_OK && rsp_tdata[7:0] == 8'h00))
      else $error("status-only result without error code");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

/* tb/jfme_frame_checker.sv */
`timescale 1ns / 100ps
// Checker for the frame marker extractor: it predicts the results of each byte and compares them.
module jfme_frame_checker import jfme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [7:0] out_byte, [27:8] frame_length,
                                    // [46:28] start_offset, [47] zero
   input  logic        rsp_tlast,
   input  logic [2:0]  rsp_tuser,   // [0] is_data, [2:1] status
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned frames_closed,
   output int unsigned no_start_reports,
   output int unsigned no_end_reports
);

   typedef enum logic [1:0] {HUNT_SOI, IN_FRAME, FRAME_DONE} scan_phase_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                is_data;
      logic                frame_last;
      logic [LENGTH_W-1:0] frame_length;
      logic [OFFSET_W-1:0] start_offset;
      logic [1:0]          status;
   } frame_result_type;

   scan_phase_type      scan_phase = HUNT_SOI;
   logic [7:0]          prev_byte = '0;
   logic                prev_seen = 1'b0;
   logic [POS_W-1:0]    scan_pos = '0;
   logic [OFFSET_W-1:0] soi_offset = '0;
   logic [LENGTH_W-1:0] frame_bytes = '0;

   frame_result_type expected_results[$];

   int unsigned fail_total = 0;
   int unsigned closed_total = 0;
   int unsigned no_start_total = 0;
   int unsigned no_end_total = 0;

   function automatic frame_result_type make_result(input logic [7:0] value,
                                                    input logic data,
                                                    input logic last,
                                                    input logic [LENGTH_W-1:0] length,
                                                    input logic [OFFSET_W-1:0] offset,
                                                    input logic [1:0] code);
      frame_result_type r;
      r.out_byte     = value;
      r.is_data      = data;
      r.frame_last   = last;
      r.frame_length = length;
      r.start_offset = offset;
      r.status       = code;
      return r;
   endfunction

   task automatic clear_scan();
      scan_phase  = HUNT_SOI;
      prev_byte   = '0;
      prev_seen   = 1'b0;
      scan_pos    = '0;
      soi_offset  = '0;
      frame_bytes = '0;
   endtask

   task automatic predict_byte(input logic [7:0] value, input logic buffer_end);
      logic at_end;
      logic prev_ff;
      // The last position of the buffer closes it whether or not the flag is set.
      at_end  = buffer_end || (scan_pos >= LAST_POS);
      prev_ff = prev_seen && (prev_byte == MARKER_PREFIX);
      case (scan_phase)
         HUNT_SOI: begin
            if (prev_ff && value == MARKER_SOI) begin
               soi_offset  = OFFSET_W'(scan_pos - 1'b1);
               frame_bytes = LENGTH_W'(2);
               expected_results.push_back(make_result(MARKER_PREFIX, 1'b1, 1'b0, '0,
                                                      soi_offset, ST_OK));
               expected_results.push_back(make_result(MARKER_SOI, 1'b1, 1'b0, '0,
                                                      soi_offset, ST_OK));
               scan_phase = IN_FRAME;
            end
            prev_byte = value;
            prev_seen = 1'b1;
         end
         IN_FRAME: begin
            frame_bytes = frame_bytes + 1'b1;
            if (prev_ff && value == MARKER_EOI) begin
               expected_results.push_back(make_result(value, 1'b1, 1'b1, frame_bytes,
                                                      soi_offset, ST_OK));
               scan_phase = FRAME_DONE;
               closed_total++;
            end else begin
               expected_results.push_back(make_result(value, 1'b1, 1'b0, '0,
                                                      soi_offset, ST_OK));
            end
            prev_byte = value;
            prev_seen = 1'b1;
         end
         default: ;
      endcase
      scan_pos = scan_pos + 1'b1;
      if (at_end) begin
         if (scan_phase == HUNT_SOI) begin
            expected_results.push_back(make_result('0, 1'b0, 1'b0, '0, '0, ST_NO_START));
            no_start_total++;
         end else if (scan_phase == IN_FRAME) begin
            expected_results.push_back(make_result('0, 1'b0, 1'b0, '0, soi_offset,
                                                   ST_NO_END));
            no_end_total++;
         end
         clear_scan();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_total++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      frame_result_type want;
      if (reset) begin
         clear_scan();
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_total++;
               $error("result transfer 0x%0h arrived with nothing expected", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("is_data", want.is_data, rsp_tuser[0]);
               check_field("frame_last", want.frame_last, rsp_tlast);
               check_field("frame_length", want.frame_length, rsp_tdata[27:8]);
               check_field("start_offset", want.start_offset, rsp_tdata[46:28]);
               check_field("status", want.status, rsp_tuser[2:1]);
               check_field("tdata_pad", '0, rsp_tdata[47]);
            end
         end
      end
      failures         <= fail_total;
      pending          <= expected_results.size();
      frames_closed    <= closed_total;
      no_start_reports <= no_start_total;
      no_end_reports   <= no_end_total;
   end

endmodule

/* tb/jpeg_frame_marker_extractor_unit_test.sv */
`timescale 1ns / 100ps
// Testbench top of the frame marker extractor: drives capture buffers and gives the verdict.
module jpeg_frame_marker_extractor_unit_test;
   import jfme_pkg::*;

   localparam int unsigned RANDOM_ITEMS    = 320;
   localparam int unsigned MAX_GAP         = 14;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES    = 60;
   localparam int unsigned CYCLE_LIMIT     = 200_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [7:0] out_byte, [27:8] frame_length,
                             // [46:28] start_offset, [47] zero
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;   // [0] is_data, [2:1] status

   int unsigned failures;
   int unsigned pending;
   int unsigned frames_closed;
   int unsigned no_start_reports;
   int unsigned no_end_reports;

   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned buffers_sent = 0;
   int unsigned tx_calm = 0;
   int unsigned rx_calm = 0;
   bit          hold_off_pending = 1'b0;
   logic [7:0]  capture[$];

   jpeg_frame_marker_extractor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   jfme_frame_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser),
      .failures         (failures),
      .pending          (pending),
      .frames_closed    (frames_closed),
      .no_start_reports (no_start_reports),
      .no_end_reports   (no_end_reports)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Gaps come in runs: now and then a stretch of back-to-back transfers, otherwise
   // mostly short waits with the odd long one.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 2);
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Marker bytes are drawn far more often than chance would give them.
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 7))
         0:       return MARKER_PREFIX;
         1:       return MARKER_SOI;
         2:       return MARKER_EOI;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic buffer_end);
      int unsigned gap;
      gap = pick_gap(tx_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= value;
      req_tlast  <= buffer_end;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_capture();
      foreach (capture[i])
         send_byte(capture[i], i == capture.size() - 1);
      buffers_sent++;
   endtask

   initial begin : receiver
      int unsigned pause;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            pause = HOLD_OFF_CYCLES;
         end else begin
            pause = pick_gap(rx_calm);
         end
         if (pause != 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned kind;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A prefix on the final byte must not pair with the first byte of the next buffer.
      capture = '{MARKER_PREFIX};
      send_capture();
      capture = '{MARKER_SOI, 8'h00};
      send_capture();
      // D9 right after the start marker, FF D8 inside the frame, FF FF before the end
      // marker and a byte dropped after it.
      capture = '{MARKER_PREFIX, MARKER_SOI, MARKER_EOI, MARKER_PREFIX, MARKER_SOI,
                  MARKER_PREFIX, MARKER_PREFIX, MARKER_EOI, 8'h55};
      send_capture();
      // Start marker on the final byte.
      capture = '{MARKER_PREFIX, MARKER_SOI};
      send_capture();
      // Frame cut off by the buffer end.
      capture = '{MARKER_PREFIX, MARKER_SOI, 8'h00, MARKER_PREFIX};
      send_capture();
      // An end marker ahead of the start is ignored; the frame closes on the final byte.
      capture = '{MARKER_PREFIX, MARKER_EOI, MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX,
                  MARKER_EOI};
      send_capture();

      hold_off_pending = 1'b1;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         capture.delete();
         kind = $urandom_range(0, 19);
         if (kind < 16) begin
            repeat ($urandom_range(0, 3)) capture.push_back(any_byte());
            capture.push_back(MARKER_PREFIX);
            capture.push_back(MARKER_SOI);
            if (kind < 11) begin
               repeat ($urandom_range(0, 10)) capture.push_back(any_byte());
               capture.push_back(MARKER_PREFIX);
               capture.push_back(MARKER_EOI);
               repeat ($urandom_range(0, 3)) capture.push_back(any_byte());
            end else if (kind < 14) begin
               repeat ($urandom_range(1, 8)) capture.push_back(any_byte());
            end
         end else begin
            repeat ($urandom_range(1, 12)) capture.push_back(any_byte());
         end
         random_sent += capture.size();
         send_capture();
      end
      req_tvalid <= 1'b0;

      // The checker's counts are registered, so let the last transfer register first.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending != 0)
         $error("%0d expected results never arrived", pending);
      $display("Sent %0d bytes in %0d capture buffers, with marker corner cases up front.",
               bytes_sent, buffers_sent);
      $display("Frames closed: %0d, buffers with no start marker: %0d, frames cut off: %0d.",
               frames_closed, no_start_reports, no_end_reports);
      if (failures == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
